// ===== rtl/pyramid_downsampler_half_twothirds_macros.svh =====
// Assertion macros for the pyramid downsampler.
// Used by the top level only; needs a clock named aclk and reset aresetn in scope.
`ifndef PYRAMID_DOWNSAMPLER_HALF_TWOTHIRDS_MACROS_SVH
`define PYRAMID_DOWNSAMPLER_HALF_TWOTHIRDS_MACROS_SVH

`ifndef SYNTHESIS
`define PDHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define PDHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PDHT_ASSERT(lbl, prop, msg)
`define PDHT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/pdht_pkg.sv =====
// Shared types and constants of the pyramid downsampler.
// No dependencies; the RTL modules other than pdht_line_ram refer to it by scoped names.
`default_nettype none

package pdht_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = 12;
    localparam int EH_W   = 13;
    localparam int DX_W   = 11;
    localparam int DY_W   = 12;
    localparam int SUM_W  = 12;

    localparam int SRC_WIDTH_W  = 12;
    localparam int SRC_HEIGHT_W = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam int MIN_DIM = 3;
    localparam logic [EW_W-1:0] EW_RESET = EW_W'((640 > MAX_WIDTH) ? MAX_WIDTH : 640);
    localparam logic [EH_W-1:0] EH_RESET = EH_W'(480);

    // last phase of a block along one axis
    localparam logic [1:0] PH_LAST_HALF  = 2'd1;
    localparam logic [1:0] PH_LAST_THIRD = 2'd2;

    // x/9 as (x * 3641) >> 15, exact for x < 32768
    localparam int DIV9_W = 12;
    localparam logic [DIV9_W-1:0] DIV9_MUL = 12'd3641;
    localparam int DIV9_SHIFT = 15;
    localparam int HALF_SHIFT = 2;

    localparam int NUM_LANES = 4;
    localparam int LANE_W    = 2;
    localparam logic [LANE_W-1:0] LAST_LANE_HALF  = 2'd0;
    localparam logic [LANE_W-1:0] LAST_LANE_THIRD = 2'd3;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_HALF,
        RES_THIRD
    } res_kind_t;

    typedef struct packed {
        logic              we1;
        logic              re1;
        logic              we2;
        logic              re2;
        logic [COL_W-1:0]  addr;
        logic [PIX_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        res_kind_t         kind;
        logic [PIX_W-1:0]  pixel;
        logic [PIX_W-1:0]  held0;
        logic [PIX_W-1:0]  held1;
        logic [DX_W-1:0]   dx;
        logic [DY_W-1:0]   dy;
        logic              eof;
    } s1_t;

    typedef struct packed {
        logic              valid;
        res_kind_t         kind;
        logic [SUM_W-1:0]  sum0;
        logic [SUM_W-1:0]  sum1;
        logic [SUM_W-1:0]  sum2;
        logic [SUM_W-1:0]  sum3;
        logic [DX_W-1:0]   dx;
        logic [DY_W-1:0]   dy;
        logic              eof;
    } s2_t;

endpackage

`default_nettype wire

// ===== rtl/pdht_line_ram.sv =====
// Generic single-port line RAM with registered read data.
// No dependencies.
`default_nettype none

module pdht_line_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/pdht_front.sv =====
// Input side: configuration registers, raster counters, held pixels,
// line RAM requests and the first pipeline stage. Uses pdht_pkg.
`default_nettype none

module pdht_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    input  wire logic [pdht_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pdht_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [pdht_pkg::PIX_W-1:0]         s_pixel,
    input  wire logic                               s1_adv,
    output pdht_pkg::s1_t                           s1,
    output pdht_pkg::mem_req_t                      mem_req
);

    localparam int COL_W = pdht_pkg::COL_W;
    localparam int ROW_W = pdht_pkg::ROW_W;
    localparam int EW_W  = pdht_pkg::EW_W;
    localparam int EH_W  = pdht_pkg::EH_W;

    logic                        mode_reg;
    logic [EW_W-1:0]             ew_reg, ew_next;
    logic [EH_W-1:0]             eh_reg, eh_next;
    logic [COL_W-1:0]            col_reg;
    logic [ROW_W-1:0]            row_reg;
    logic [1:0]                  col_ph_reg, row_ph_reg;
    logic [pdht_pkg::DX_W-1:0]   dx_reg;
    logic [pdht_pkg::DY_W-1:0]   dy_reg;
    logic [pdht_pkg::PIX_W-1:0]  held0_reg, held1_reg;
    pdht_pkg::s1_t               s1_reg, s1_next;

    logic                              accept, cfg_hit;
    logic [1:0]                        ph_last, step;
    logic [COL_W:0]                    col_inc, col_span;
    logic [ROW_W:0]                    row_inc, row_span;
    logic                              row_end, frame_end, col_tail, row_tail;
    logic [pdht_pkg::SRC_WIDTH_W-1:0]  w_in;
    logic [pdht_pkg::SRC_HEIGHT_W-1:0] h_in;

    assign accept  = s_valid && s_ready;
    assign s_ready = !s1_reg.valid || s1_adv;
    assign ph_last = mode_reg ? pdht_pkg::PH_LAST_THIRD : pdht_pkg::PH_LAST_HALF;
    assign step    = ph_last;

    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign row_end   = col_inc >= (COL_W+1)'(ew_reg);
    assign frame_end = row_inc >= (ROW_W+1)'(eh_reg);
    // block is the last one along an axis when at most a block's span remain
    assign col_span  = {1'b0, col_reg} + (COL_W+1)'(ph_last) + 1'b1;
    assign row_span  = {1'b0, row_reg} + (ROW_W+1)'(ph_last) + 1'b1;
    assign col_tail  = col_span >= (COL_W+1)'(ew_reg);
    assign row_tail  = row_span >= (ROW_W+1)'(eh_reg);

    assign w_in = cfg_data[pdht_pkg::SRC_WIDTH_W-1:0];
    assign h_in = cfg_data[pdht_pkg::SRC_HEIGHT_W-1:0];

    always_comb begin
        ew_next = ew_reg;
        eh_next = eh_reg;
        cfg_hit = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                pdht_pkg::CFG_MODE: begin
                    cfg_hit = 1'b1;
                end
                pdht_pkg::CFG_WIDTH: begin
                    cfg_hit = 1'b1;
                    if (int'(w_in) < pdht_pkg::MIN_DIM) begin
                        ew_next = EW_W'(pdht_pkg::MIN_DIM);
                    end else if (int'(w_in) > pdht_pkg::MAX_WIDTH) begin
                        ew_next = EW_W'(pdht_pkg::MAX_WIDTH);
                    end else begin
                        ew_next = EW_W'(w_in);
                    end
                end
                pdht_pkg::CFG_HEIGHT: begin
                    cfg_hit = 1'b1;
                    if (int'(h_in) < pdht_pkg::MIN_DIM) begin
                        eh_next = EH_W'(pdht_pkg::MIN_DIM);
                    end else if (int'(h_in) > pdht_pkg::MAX_HEIGHT) begin
                        eh_next = EH_W'(pdht_pkg::MAX_HEIGHT);
                    end else begin
                        eh_next = EH_W'(h_in);
                    end
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        s1_next       = s1_reg;
        s1_next.valid = 1'b1;
        s1_next.pixel = s_pixel;
        s1_next.held0 = held0_reg;
        s1_next.held1 = held1_reg;
        s1_next.dx    = dx_reg;
        s1_next.dy    = dy_reg;
        s1_next.eof   = col_tail && row_tail;
        if (col_ph_reg == ph_last && row_ph_reg == ph_last) begin
            s1_next.kind = mode_reg ? pdht_pkg::RES_THIRD : pdht_pkg::RES_HALF;
        end else begin
            s1_next.kind = pdht_pkg::RES_NONE;
        end
    end

    // two-thirds: rows 0/1 of a block fill the stores, row 2 reads both
    always_comb begin
        mem_req.addr  = col_reg;
        mem_req.wdata = s_pixel;
        mem_req.we1   = accept && row_ph_reg == 2'd0;
        mem_req.we2   = accept && mode_reg && row_ph_reg == 2'd1;
        mem_req.re1   = accept && row_ph_reg == ph_last;
        mem_req.re2   = accept && mode_reg && row_ph_reg == ph_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            ew_reg     <= pdht_pkg::EW_RESET;
            eh_reg     <= pdht_pkg::EH_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            col_ph_reg <= '0;
            row_ph_reg <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            held0_reg  <= '0;
            held1_reg  <= '0;
        end else if (cfg_hit) begin
            if (cfg_index == pdht_pkg::CFG_MODE) begin
                mode_reg <= cfg_data[0];
            end
            ew_reg     <= ew_next;
            eh_reg     <= eh_next;
            col_reg    <= '0;
            row_reg    <= '0;
            col_ph_reg <= '0;
            row_ph_reg <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            held0_reg  <= '0;
            held1_reg  <= '0;
        end else if (accept) begin
            held0_reg <= held1_reg;
            held1_reg <= s_pixel;
            if (row_end) begin
                col_reg    <= '0;
                col_ph_reg <= '0;
                dx_reg     <= '0;
                if (frame_end) begin
                    row_reg    <= '0;
                    row_ph_reg <= '0;
                    dy_reg     <= '0;
                end else begin
                    row_reg <= row_inc[ROW_W-1:0];
                    if (row_ph_reg == ph_last) begin
                        row_ph_reg <= '0;
                        dy_reg     <= dy_reg + pdht_pkg::DY_W'(step);
                    end else begin
                        row_ph_reg <= row_ph_reg + 2'd1;
                    end
                end
            end else begin
                col_reg <= col_inc[COL_W-1:0];
                if (col_ph_reg == ph_last) begin
                    col_ph_reg <= '0;
                    dx_reg     <= dx_reg + pdht_pkg::DX_W'(step);
                end else begin
                    col_ph_reg <= col_ph_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
        end else if (accept) begin
            s1_reg <= s1_next;
        end else if (s1_adv) begin
            s1_reg.valid <= 1'b0;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

// ===== rtl/pdht_calc.sv =====
// Second stage: column taps of the line RAM read data and block sums,
// weighted in two-thirds mode. Uses pdht_pkg.
`default_nettype none

module pdht_calc (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pdht_pkg::s1_t               s1,
    input  wire logic [pdht_pkg::PIX_W-1:0]  rdata1,
    input  wire logic [pdht_pkg::PIX_W-1:0]  rdata2,
    input  wire logic                        s2_ready,
    output logic                             s1_adv,
    output pdht_pkg::s2_t                    s2
);

    localparam int SUM_W = pdht_pkg::SUM_W;

    // tap a = column c-1, tap b = column c-2 of the row being read
    logic [pdht_pkg::PIX_W-1:0] t1a_reg, t1b_reg, t2a_reg, t2b_reg;
    pdht_pkg::s2_t              s2_reg, s2_next;
    logic                       s2_adv, s1_has_res;

    function automatic logic [SUM_W-1:0] wsum(
        input logic [pdht_pkg::PIX_W-1:0] corner,
        input logic [pdht_pkg::PIX_W-1:0] edge_a,
        input logic [pdht_pkg::PIX_W-1:0] edge_b,
        input logic [pdht_pkg::PIX_W-1:0] mid
    );
        logic [SUM_W-1:0] acc;
        acc = (SUM_W'(corner) << 2) + ((SUM_W'(edge_a) + SUM_W'(edge_b)) << 1)
            + SUM_W'(mid);
        return acc;
    endfunction

    assign s1_has_res = s1.kind != pdht_pkg::RES_NONE;
    assign s2_adv     = s2_reg.valid && s2_ready;
    assign s1_adv     = s1.valid && (!s1_has_res || !s2_reg.valid || s2_ready);

    always_comb begin
        s2_next       = s2_reg;
        s2_next.valid = 1'b1;
        s2_next.kind  = s1.kind;
        s2_next.dx    = s1.dx;
        s2_next.dy    = s1.dy;
        s2_next.eof   = s1.eof;
        if (s1.kind == pdht_pkg::RES_THIRD) begin
            s2_next.sum0 = wsum(t1b_reg, t1a_reg, t2b_reg, t2a_reg);
            s2_next.sum1 = wsum(rdata1,  t1a_reg, rdata2,  t2a_reg);
            s2_next.sum2 = wsum(s1.held0, s1.held1, t2b_reg, t2a_reg);
            s2_next.sum3 = wsum(s1.pixel, s1.held1, rdata2,  t2a_reg);
        end else begin
            s2_next.sum0 = SUM_W'(t1a_reg) + SUM_W'(rdata1) + SUM_W'(s1.held1)
                         + SUM_W'(s1.pixel);
            s2_next.sum1 = '0;
            s2_next.sum2 = '0;
            s2_next.sum3 = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            t1b_reg <= t1a_reg;
            t1a_reg <= rdata1;
            t2b_reg <= t2a_reg;
            t2a_reg <= rdata2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.valid <= 1'b0;
        end else if (s1_adv && s1_has_res) begin
            s2_reg <= s2_next;
        end else if (s2_adv) begin
            s2_reg.valid <= 1'b0;
        end
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

// ===== rtl/pdht_outq.sv =====
// Output stage: divides the block sums and sends the one or four results
// of a block one transfer at a time. Uses pdht_pkg.
`default_nettype none

module pdht_outq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pdht_pkg::s2_t               s2,
    output logic                             s2_ready,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [pdht_pkg::PIX_W-1:0]       m_out_pixel,
    output logic [pdht_pkg::DX_W-1:0]        m_dest_x,
    output logic [pdht_pkg::DY_W-1:0]        m_dest_y,
    output logic                             m_last_of_item,
    output logic                             m_end_of_frame
);

    localparam int PIX_W  = pdht_pkg::PIX_W;
    localparam int LANE_W = pdht_pkg::LANE_W;

    logic                        b_valid_reg;
    logic [LANE_W-1:0]           idx_reg, last_reg, last_next;
    logic [PIX_W-1:0]            val_reg [pdht_pkg::NUM_LANES];
    logic [PIX_W-1:0]            val_next [pdht_pkg::NUM_LANES];
    logic [pdht_pkg::DX_W-1:0]   dx_reg;
    logic [pdht_pkg::DY_W-1:0]   dy_reg;
    logic                        eof_reg;
    logic                        take, at_last, done, load;

    function automatic logic [PIX_W-1:0] div9(input logic [pdht_pkg::SUM_W-1:0] sum);
        logic [pdht_pkg::SUM_W+pdht_pkg::DIV9_W-1:0] prod;
        prod = {{pdht_pkg::DIV9_W{1'b0}}, sum}
             * {{pdht_pkg::SUM_W{1'b0}}, pdht_pkg::DIV9_MUL};
        return prod[pdht_pkg::DIV9_SHIFT +: PIX_W];
    endfunction

    assign take     = b_valid_reg && m_ready;
    assign at_last  = idx_reg == last_reg;
    assign done     = take && at_last;
    assign s2_ready = !b_valid_reg || done;
    assign load     = s2.valid && s2_ready;

    always_comb begin
        case (s2.kind)
            pdht_pkg::RES_THIRD: begin
                last_next   = pdht_pkg::LAST_LANE_THIRD;
                val_next[0] = div9(s2.sum0);
                val_next[1] = div9(s2.sum1);
                val_next[2] = div9(s2.sum2);
                val_next[3] = div9(s2.sum3);
            end
            default: begin
                last_next   = pdht_pkg::LAST_LANE_HALF;
                val_next[0] = s2.sum0[pdht_pkg::HALF_SHIFT +: PIX_W];
                val_next[1] = '0;
                val_next[2] = '0;
                val_next[3] = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (load) begin
            b_valid_reg <= 1'b1;
            idx_reg     <= '0;
        end else if (done) begin
            b_valid_reg <= 1'b0;
        end else if (take) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            val_reg  <= val_next;
            last_reg <= last_next;
            dx_reg   <= s2.dx;
            dy_reg   <= s2.dy;
            eof_reg  <= s2.eof;
        end
    end

    // lane order: top left, top right, bottom left, bottom right
    assign m_valid        = b_valid_reg;
    assign m_out_pixel    = val_reg[idx_reg];
    assign m_dest_x       = dx_reg + pdht_pkg::DX_W'(idx_reg[0]);
    assign m_dest_y       = dy_reg + pdht_pkg::DY_W'(idx_reg[1]);
    assign m_last_of_item = at_last;
    assign m_end_of_frame = eof_reg && at_last;

endmodule

`default_nettype wire

// ===== rtl/pyramid_downsampler_half_twothirds.sv =====
// Top level of the half / two-thirds pyramid downsampler.
// Depends on pdht_pkg, pdht_front, pdht_line_ram, pdht_calc, pdht_outq and the macros header.
//
//  channel   ports                         moves
//  --------  ----------------------------  ------------------------------------
//  config    cfg_valid/ready index data    one register write per transfer
//  input     s_valid/ready s_pixel         one source pixel, raster order
//  output    m_valid/ready m_*             one layer pixel with its coordinates
//
// One pixel per clock is taken while the output does not stall; each result passes the s1,
// s2 and output bundle registers before it leaves. A two-thirds block gives four transfers
// out of one pixel, so the single output port throttles the input on each block's bottom row.
// Reset restores the register defaults and clears counters; line RAMs are not cleared.
// A stalled output holds the result bundle and backs up through the two stages to s_ready.
`default_nettype none
`include "pyramid_downsampler_half_twothirds_macros.svh"

module pyramid_downsampler_half_twothirds (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pdht_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pdht_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [pdht_pkg::PIX_W-1:0]         s_pixel,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [pdht_pkg::PIX_W-1:0]              m_out_pixel,
    output logic [pdht_pkg::DX_W-1:0]               m_dest_x,
    output logic [pdht_pkg::DY_W-1:0]               m_dest_y,
    output logic                                    m_last_of_item,
    output logic                                    m_end_of_frame
);

    pdht_pkg::s1_t              s1;
    pdht_pkg::s2_t              s2;
    pdht_pkg::mem_req_t         mem_req;
    logic                       s1_adv, s2_ready;
    logic [pdht_pkg::PIX_W-1:0] rdata1, rdata2;

    assign cfg_ready = 1'b1;

    pdht_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .s1_adv    (s1_adv),
        .s1        (s1),
        .mem_req   (mem_req)
    );

    pdht_line_ram #(
        .ADDR_W (pdht_pkg::COL_W),
        .DATA_W (pdht_pkg::PIX_W)
    ) u_line_first (
        .aclk  (aclk),
        .we    (mem_req.we1),
        .re    (mem_req.re1),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata1)
    );

    pdht_line_ram #(
        .ADDR_W (pdht_pkg::COL_W),
        .DATA_W (pdht_pkg::PIX_W)
    ) u_line_second (
        .aclk  (aclk),
        .we    (mem_req.we2),
        .re    (mem_req.re2),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata2)
    );

    pdht_calc u_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1       (s1),
        .rdata1   (rdata1),
        .rdata2   (rdata2),
        .s2_ready (s2_ready),
        .s1_adv   (s1_adv),
        .s2       (s2)
    );

    pdht_outq u_outq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s2             (s2),
        .s2_ready       (s2_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_pixel    (m_out_pixel),
        .m_dest_x       (m_dest_x),
        .m_dest_y       (m_dest_y),
        .m_last_of_item (m_last_of_item),
        .m_end_of_frame (m_end_of_frame)
    );

    `PDHT_ASSERT(a_ram1_one_port, !(mem_req.we1 && mem_req.re1), "line RAM 1 read and write together")
    `PDHT_ASSERT(a_ram2_one_port, !(mem_req.we2 && mem_req.re2), "line RAM 2 read and write together")
    `PDHT_ASSERT_IMPL(a_eof_last, m_valid && m_end_of_frame, m_last_of_item, "frame end not on last result")
    `PDHT_ASSERT_IMPL(a_bundle_cont, m_valid && m_ready && !m_last_of_item, ##1 m_valid, "result bundle broken")

endmodule

`default_nettype wire
